// File: hdl/lz77_pkg.sv
// ----------------------------------------------------------------------------
// lz77_pkg
// Shared types, constants and DEFLATE code tables for the token expander.
// ----------------------------------------------------------------------------
package lz77_pkg;

  localparam int unsigned WindowDepth = 4096;
  localparam int unsigned PtrW        = $clog2(WindowDepth);
  localparam int unsigned FillW       = PtrW + 1;
  localparam int unsigned Lanes       = 8;
  localparam int unsigned LaneCntW    = 4;
  localparam int unsigned ElemW       = 9;
  localparam int unsigned LenW        = 9;
  localparam int unsigned DistW       = 16;

  localparam logic [9:0] SymEnd     = 10'd511;
  localparam logic [9:0] SymLenLast = 10'd540;
  localparam logic [4:0] DistCodes  = 5'd30;

  localparam logic [1:0] ErrNone    = 2'd0;
  localparam logic [1:0] ErrUnfill  = 2'd1;
  localparam logic [1:0] ErrWindow  = 2'd2;
  localparam logic [1:0] ErrBadCode = 2'd3;

  typedef struct packed {
    logic [9:0]  symbol;
    logic [4:0]  length_extra;
    logic [4:0]  dist_code;
    logic [12:0] distance_extra;
  } token_t;

  typedef struct packed {
    logic [Lanes-1:0][ElemW-1:0] lane;
    logic [LaneCntW-1:0]         lane_count;
    logic                        run_last;
    logic                        stream_end;
    logic [1:0]                  error_code;
  } result_t;

  function automatic logic [LenW-1:0] len_base(input logic [4:0] c);
    unique case (c)
      5'd0: len_base = 9'd3;    5'd1: len_base = 9'd4;    5'd2: len_base = 9'd5;
      5'd3: len_base = 9'd6;    5'd4: len_base = 9'd7;    5'd5: len_base = 9'd8;
      5'd6: len_base = 9'd9;    5'd7: len_base = 9'd10;   5'd8: len_base = 9'd11;
      5'd9: len_base = 9'd13;   5'd10: len_base = 9'd15;  5'd11: len_base = 9'd17;
      5'd12: len_base = 9'd19;  5'd13: len_base = 9'd23;  5'd14: len_base = 9'd27;
      5'd15: len_base = 9'd31;  5'd16: len_base = 9'd35;  5'd17: len_base = 9'd43;
      5'd18: len_base = 9'd51;  5'd19: len_base = 9'd59;  5'd20: len_base = 9'd67;
      5'd21: len_base = 9'd83;  5'd22: len_base = 9'd99;  5'd23: len_base = 9'd115;
      5'd24: len_base = 9'd131; 5'd25: len_base = 9'd163; 5'd26: len_base = 9'd195;
      5'd27: len_base = 9'd227; default: len_base = 9'd258;
    endcase
  endfunction

  function automatic logic [4:0] len_mask(input logic [4:0] c);
    if (c < 5'd8 || c > 5'd27) len_mask = 5'd0;
    else len_mask = 5'((6'd1 << ((c - 5'd4) >> 2)) - 6'd1);
  endfunction

  function automatic logic [DistW-1:0] dist_base(input logic [4:0] c);
    logic [3:0] b;
    if (c < 5'd4) begin
      dist_base = 16'(c) + 16'd1;
    end else begin
      b = 4'((c >> 1) - 5'd1);
      dist_base = (16'd1 << (b + 4'd1)) + (16'(c[0]) << b) + 16'd1;
    end
  endfunction

  function automatic logic [12:0] dist_mask(input logic [4:0] c);
    if (c < 5'd4) dist_mask = 13'd0;
    else dist_mask = 13'((14'd1 << ((c >> 1) - 5'd1)) - 14'd1);
  endfunction

endpackage

// File: hdl/lz77_stream_if.sv
// ----------------------------------------------------------------------------
// lz77_stream_if
// Valid/ready channels for tokens and results.
// ----------------------------------------------------------------------------
interface lz77_token_if;
  logic             valid;
  logic             ready;
  lz77_pkg::token_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lz77_result_if;
  logic              valid;
  logic              ready;
  lz77_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/lz77_history_ram.sv
// ----------------------------------------------------------------------------
// lz77_history_ram
// History window: one write, one registered read port.
// ----------------------------------------------------------------------------
module lz77_history_ram (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [lz77_pkg::PtrW-1:0]             waddr_i,
  input  logic [lz77_pkg::ElemW-1:0]            wdata_i,
  input  logic [lz77_pkg::PtrW-1:0]             raddr_i,
  output logic [lz77_pkg::ElemW-1:0]            rdata_o
);
  logic [lz77_pkg::ElemW-1:0] mem [lz77_pkg::WindowDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: hdl/lz77_token_expander.sv
// ----------------------------------------------------------------------------
// lz77_token_expander
// DEFLATE back-reference expander over a 4096-entry history memory.
// ----------------------------------------------------------------------------
// One token per transaction. A literal, the end symbol or an error is taken
// and decoded, then its result moves into the output register, and the next
// token can be taken straight after. A match is copied one element at a time
// through the single-read-port history memory: read issued, data back in the
// next cycle, written back at the write pointer and gathered into lanes. Each
// group of up to eight elements then moves into the output register, and the
// next token is taken only after the last group has moved in. A result still
// waiting in the output register stalls the expander only when the next result
// is ready to move in. Overlap needs no forwarding since distance is at least 1
// and a read is issued only after the previous element's write is done. Errors
// and the end symbol reset the stream.
module lz77_token_expander (
  input  logic          clk_i,
  input  logic          rst_ni,
  lz77_token_if.sink    tok_i,
  lz77_result_if.source res_o
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StCopy = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  localparam int unsigned PW = lz77_pkg::PtrW;

  logic [1:0]                 state_q, state_d;
  logic [PW-1:0]              wp_q, wp_d, src_q, src_d;
  logic [lz77_pkg::FillW-1:0] fill_q, fill_d;
  logic [lz77_pkg::LenW-1:0]  left_q, left_d;
  lz77_pkg::result_t          out_q, out_d, acc_q, acc_d;
  logic                       ov_q, ov_d;

  logic                       we;
  logic [lz77_pkg::ElemW-1:0] wdata, rdata;

  // token decode
  lz77_pkg::token_t           t;
  logic [4:0]                 lcode;
  logic [lz77_pkg::LenW-1:0]  length;
  logic [lz77_pkg::DistW-1:0] distance;

  assign t     = tok_i.data;
  assign lcode = 5'(t.symbol - 10'd512);
  assign length = lz77_pkg::len_base(lcode) + 9'(t.length_extra & lz77_pkg::len_mask(lcode));
  assign distance = lz77_pkg::dist_base(t.dist_code)
                  + 16'(t.distance_extra & lz77_pkg::dist_mask(t.dist_code));

  lz77_history_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(wp_q), .wdata_i(wdata),
    .raddr_i(src_q), .rdata_o(rdata)
  );

  assign tok_i.ready = (state_q == StIdle);
  assign res_o.valid = ov_q;
  assign res_o.data  = out_q;

  always_comb begin
    state_d = state_q; wp_d = wp_q; src_d = src_q; fill_d = fill_q;
    left_d = left_q; acc_d = acc_q; out_d = out_q; ov_d = ov_q;
    we = 1'b0; wdata = t.symbol[lz77_pkg::ElemW-1:0];
    if (res_o.ready) ov_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (tok_i.valid) begin
          acc_d = '0;
          acc_d.run_last = 1'b1;
          priority if (t.symbol < lz77_pkg::SymEnd) begin
            we = 1'b1;
            wp_d = wp_q + 1'b1;
            if (fill_q != lz77_pkg::FillW'(lz77_pkg::WindowDepth)) fill_d = fill_q + 1'b1;
            acc_d.lane[0] = t.symbol[lz77_pkg::ElemW-1:0];
            acc_d.lane_count = 4'd1;
          end else if (t.symbol == lz77_pkg::SymEnd) begin
            acc_d.stream_end = 1'b1;
            wp_d = '0; fill_d = '0;
          end else if (t.symbol > lz77_pkg::SymLenLast ||
                       t.dist_code >= lz77_pkg::DistCodes) begin
            acc_d.error_code = lz77_pkg::ErrBadCode;
            wp_d = '0; fill_d = '0;
          end else if (distance > lz77_pkg::DistW'(lz77_pkg::WindowDepth)) begin
            acc_d.error_code = lz77_pkg::ErrWindow;
            wp_d = '0; fill_d = '0;
          end else if (distance > lz77_pkg::DistW'(fill_q)) begin
            acc_d.error_code = lz77_pkg::ErrUnfill;
            wp_d = '0; fill_d = '0;
          end else begin
            acc_d.run_last = 1'b0;
            src_d  = wp_q - distance[PW-1:0];
            left_d = length;
          end
          state_d = acc_d.run_last ? StOut : StRead;
        end
      end
      StRead: state_d = StCopy;  // memory read in flight
      StCopy: begin
        we = 1'b1; wdata = rdata;
        wp_d = wp_q + 1'b1;
        src_d = src_q + 1'b1;
        if (fill_q != lz77_pkg::FillW'(lz77_pkg::WindowDepth)) fill_d = fill_q + 1'b1;
        acc_d.lane[acc_q.lane_count[2:0]] = rdata;
        acc_d.lane_count = acc_q.lane_count + 1'b1;
        left_d = left_q - 1'b1;
        acc_d.run_last = (left_q == 9'd1);
        if (acc_d.run_last || acc_d.lane_count == 4'(lz77_pkg::Lanes)) state_d = StOut;
        else state_d = StRead;
      end
      default: begin  // StOut
        if (!ov_d) begin
          out_d = acc_q; ov_d = 1'b1;
          acc_d = '0;
          state_d = acc_q.run_last ? StIdle : StRead;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; wp_q <= '0; fill_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; wp_q <= wp_d; fill_q <= fill_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d; left_q <= left_d; acc_q <= acc_d; out_q <= out_d;
  end
endmodule
